[design/detector_coincidence_scaler_core_defines.svh]
// Assertion macros shared by the checker of the coincidence scaler.
`ifndef DETECTOR_COINCIDENCE_SCALER_CORE_DEFINES_SVH
`define DETECTOR_COINCIDENCE_SCALER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("coincidence scaler check failed");

// The consequent must hold in the cycle after the antecedent.
`define DCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("coincidence scaler check failed");

// Checked also while reset is high.
`define DCS_ASSERT_RESET(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("coincidence scaler reset check failed");

`endif

[design/dcs_pkg.sv]
// ----------------------------------------------------------------------------
// dcs_pkg
// Types, constants and tables shared by the coincidence scaler modules.
// ----------------------------------------------------------------------------
package dcs_pkg;

   localparam int PADS_PER_PLANE = 256;
   localparam int COUNTER_BITS   = 32;
   localparam int NUM_COUNTERS   = 64;
   localparam int GROUP_SIZE     = 8;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [15:0] WIN_LOW      = 16'd10;
   localparam logic [15:0] WIN_HIGH     = 16'd4080;
   localparam logic [8:0]  PAD_HITS_MAX = 9'd511;
   localparam logic [4:0]  ION_HITS_MAX = 5'd31;
   localparam logic [7:0]  ION_SEGMENTS = 8'd16;
   localparam logic [63:0] READ_MAX     = 64'hFFFF_FFFF;

   localparam logic [7:0] PMT_CHANNEL [8] = '{8'd9, 8'd11, 8'd13, 8'd15,
                                              8'd1, 8'd3, 8'd5, 8'd7};
   localparam logic [7:0] MCP_HIGH_CHANNEL [4] = '{8'd11, 8'd15, 8'd9, 8'd13};
   localparam logic [7:0] MCP_LOW_CHANNEL  [4] = '{8'd3, 8'd7, 8'd1, 8'd5};

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_EVENT  = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      SRC_TDC   = 3'd0,
      SRC_QDC   = 3'd1,
      SRC_PAD   = 3'd2,
      SRC_ANODE = 3'd3,
      SRC_ION   = 3'd4
   } source_type;

   typedef enum logic [2:0] {
      REG_TDC_LOWER   = 3'd0,
      REG_TDC_UPPER   = 3'd1,
      REG_QDC_UPPER   = 3'd2,
      REG_PED_HIGH    = 3'd3,
      REG_PED_LOW     = 3'd4,
      REG_PAD_LOWER   = 3'd5,
      REG_PAD_UPPER   = 3'd6,
      REG_ION_MIN     = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_EVENT = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [5:0]   mask;
      logic [7:0]   index;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_slot_type;

   typedef logic [5:0] subset_table_type [NUM_COUNTERS];

   // Empty set first, then singles, pairs and so on, each group in
   // lexicographic order of detector index.
   function automatic subset_table_type build_subsets();
      subset_table_type t;
      int               idx;
      int               n;
      logic [5:0]       rv;
      logic [5:0]       m;
      idx = 0;
      for (int k = 0; k < NUM_COUNTERS; k++) begin
         t[k] = '0;
      end
      for (int s = 0; s <= 6; s++) begin
         for (int r = 63; r >= 0; r--) begin
            rv = 6'(r);
            n = 0;
            for (int b = 0; b < 6; b++) begin
               n = n + int'(rv[b]);
            end
            if (n == s) begin
               m = '0;
               for (int b = 0; b < 6; b++) begin
                  if (rv[b]) begin
                     m[5 - b] = 1'b1;
                  end
               end
               t[idx] = m;
               idx = idx + 1;
            end
         end
      end
      return t;
   endfunction

   localparam subset_table_type SUBSET_MASKS = build_subsets();

endpackage

[design/dcs_queue.sv]
// ----------------------------------------------------------------------------
// dcs_queue
// Short command queue between the event front end and the counter back end.
// ----------------------------------------------------------------------------
module dcs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  dcs_pkg::cmd_slot_type push,
   output logic                  full,
   output dcs_pkg::cmd_slot_type head,
   input  logic                  pop
);

   localparam int PTR_BITS = $clog2(dcs_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(dcs_pkg::QUEUE_DEPTH + 1);

   dcs_pkg::cmd_type     entries_ff [dcs_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == CNT_BITS'(dcs_pkg::QUEUE_DEPTH));
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(dcs_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(dcs_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

[design/dcs_front.sv]
// ----------------------------------------------------------------------------
// dcs_front
// Accepts words, applies sample windows to the event state, forms the good
// mask at end of event and queues commands for the counter back end.
// ----------------------------------------------------------------------------
module dcs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic [2:0]            req_source,
   input  logic                  req_chamber,
   input  logic [7:0]            req_channel,
   input  logic [15:0]           req_sample_value,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_data,
   input  logic                  queue_full,
   output dcs_pkg::cmd_slot_type push
);

   logic [15:0] tdc_lower_ff, tdc_upper_ff;
   logic [11:0] qdc_upper_ff, ped_high_ff, ped_low_ff, pad_lower_ff, pad_upper_ff;
   logic [4:0]  ion_min_ff;

   logic [7:0]  pmt_hits_ff, pmt_hits_in;
   logic [3:0]  mcp_hits_ff, mcp_hits_in;
   logic [1:0]  anode_ok_ff, anode_ok_in;
   logic [8:0]  pad_hits_ff [2];
   logic [8:0]  pad_hits_in [2];
   logic [4:0]  ion_hits_ff, ion_hits_in;

   logic        accept;
   logic        tdc_ok, high_ok, low_ok, pad_ok, win_ok, pad_chan_ok;
   logic [5:0]  mask;
   dcs_pkg::op_type op;

   assign req_ready = !queue_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign op        = dcs_pkg::op_type'(req_operation);

   assign tdc_ok  = (req_sample_value > tdc_lower_ff) && (req_sample_value < tdc_upper_ff);
   assign high_ok = (req_sample_value > 16'(ped_high_ff)) &&
                    (req_sample_value < 16'(qdc_upper_ff));
   assign low_ok  = (req_sample_value > 16'(ped_low_ff)) &&
                    (req_sample_value < 16'(qdc_upper_ff));
   assign pad_ok  = (req_sample_value > 16'(pad_lower_ff)) &&
                    (req_sample_value < 16'(pad_upper_ff));
   assign win_ok  = (req_sample_value > dcs_pkg::WIN_LOW) &&
                    (req_sample_value < dcs_pkg::WIN_HIGH);
   assign pad_chan_ok = (9'(req_channel) < 9'(dcs_pkg::PADS_PER_PLANE));

   assign mask[0] = (pmt_hits_ff[3:0] == 4'hF);
   assign mask[1] = (mcp_hits_ff == 4'hF);
   assign mask[2] = anode_ok_ff[0] && (pad_hits_ff[0] > 9'd2);
   assign mask[3] = (pmt_hits_ff[7:4] == 4'hF);
   assign mask[4] = anode_ok_ff[1] && (pad_hits_ff[1] > 9'd2);
   assign mask[5] = (ion_hits_ff >= ion_min_ff);

   always_comb begin
      pmt_hits_in    = pmt_hits_ff;
      mcp_hits_in    = mcp_hits_ff;
      anode_ok_in    = anode_ok_ff;
      pad_hits_in[0] = pad_hits_ff[0];
      pad_hits_in[1] = pad_hits_ff[1];
      ion_hits_in    = ion_hits_ff;
      if (accept && (op == dcs_pkg::OP_SAMPLE)) begin
         unique case (dcs_pkg::source_type'(req_source))
            dcs_pkg::SRC_TDC: begin
               for (int i = 0; i < 8; i++) begin
                  if ((req_channel == dcs_pkg::PMT_CHANNEL[i]) && tdc_ok) begin
                     pmt_hits_in[i] = 1'b1;
                  end
               end
            end
            dcs_pkg::SRC_QDC: begin
               for (int i = 0; i < 4; i++) begin
                  if (((req_channel == dcs_pkg::MCP_HIGH_CHANNEL[i]) && high_ok) ||
                      ((req_channel == dcs_pkg::MCP_LOW_CHANNEL[i]) && low_ok)) begin
                     mcp_hits_in[i] = 1'b1;
                  end
               end
            end
            dcs_pkg::SRC_PAD: begin
               if (pad_chan_ok && pad_ok &&
                   (pad_hits_ff[req_chamber] != dcs_pkg::PAD_HITS_MAX)) begin
                  pad_hits_in[req_chamber] = pad_hits_ff[req_chamber] + 1'b1;
               end
            end
            dcs_pkg::SRC_ANODE: begin
               if (win_ok) begin
                  anode_ok_in[req_chamber] = 1'b1;
               end
            end
            dcs_pkg::SRC_ION: begin
               if ((req_channel < dcs_pkg::ION_SEGMENTS) && win_ok &&
                   (ion_hits_ff != dcs_pkg::ION_HITS_MAX)) begin
                  ion_hits_in = ion_hits_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else if (accept && (op == dcs_pkg::OP_EVENT)) begin
         pmt_hits_in    = '0;
         mcp_hits_in    = '0;
         anode_ok_in    = '0;
         pad_hits_in[0] = '0;
         pad_hits_in[1] = '0;
         ion_hits_in    = '0;
      end
   end

   always_comb begin
      push.valid     = accept && (op != dcs_pkg::OP_SAMPLE);
      push.cmd.mask  = mask;
      push.cmd.index = req_channel;
      unique case (op)
         dcs_pkg::OP_READ:  push.cmd.kind = dcs_pkg::CMD_READ;
         dcs_pkg::OP_CLEAR: push.cmd.kind = dcs_pkg::CMD_CLEAR;
         dcs_pkg::OP_EVENT: push.cmd.kind = dcs_pkg::CMD_EVENT;
         dcs_pkg::OP_SAMPLE: push.cmd.kind = dcs_pkg::CMD_EVENT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pmt_hits_ff    <= '0;
         mcp_hits_ff    <= '0;
         anode_ok_ff    <= '0;
         pad_hits_ff[0] <= '0;
         pad_hits_ff[1] <= '0;
         ion_hits_ff    <= '0;
      end else begin
         pmt_hits_ff    <= pmt_hits_in;
         mcp_hits_ff    <= mcp_hits_in;
         anode_ok_ff    <= anode_ok_in;
         pad_hits_ff[0] <= pad_hits_in[0];
         pad_hits_ff[1] <= pad_hits_in[1];
         ion_hits_ff    <= ion_hits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tdc_lower_ff <= 16'd1;
         tdc_upper_ff <= 16'd65535;
         qdc_upper_ff <= 12'd3840;
         ped_high_ff  <= 12'd100;
         ped_low_ff   <= 12'd20;
         pad_lower_ff <= 12'd100;
         pad_upper_ff <= 12'd990;
         ion_min_ff   <= 5'd15;
      end else if (csr_valid && csr_ready) begin
         unique case (dcs_pkg::reg_index_type'(csr_index))
            dcs_pkg::REG_TDC_LOWER: tdc_lower_ff <= csr_data;
            dcs_pkg::REG_TDC_UPPER: tdc_upper_ff <= csr_data;
            dcs_pkg::REG_QDC_UPPER: qdc_upper_ff <= csr_data[11:0];
            dcs_pkg::REG_PED_HIGH:  ped_high_ff  <= csr_data[11:0];
            dcs_pkg::REG_PED_LOW:   ped_low_ff   <= csr_data[11:0];
            dcs_pkg::REG_PAD_LOWER: pad_lower_ff <= csr_data[11:0];
            dcs_pkg::REG_PAD_UPPER: pad_upper_ff <= csr_data[11:0];
            dcs_pkg::REG_ION_MIN:   ion_min_ff   <= csr_data[4:0];
         endcase
      end
   end

endmodule

[design/dcs_back.sv]
// ----------------------------------------------------------------------------
// dcs_back
// Subset counters, the counter read stage and the result register.
// ----------------------------------------------------------------------------
module dcs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  dcs_pkg::cmd_slot_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [5:0]            rsp_good_mask,
   output logic [31:0]           rsp_count_value,
   output logic                  rsp_is_read
);

   localparam int CB = dcs_pkg::COUNTER_BITS;

   logic [CB-1:0] counters_ff [dcs_pkg::NUM_COUNTERS];
   logic [CB-1:0] group_ff [dcs_pkg::GROUP_SIZE];
   logic [CB-1:0] group_in [dcs_pkg::GROUP_SIZE];
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_is_read_ff;
   logic          s1_oob_ff;
   logic [5:0]    s1_mask_ff;
   logic [2:0]    s1_low_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [5:0]    rsp_mask_ff;
   logic [31:0]   rsp_count_ff;
   logic          rsp_is_read_ff;
   logic          out_free;
   logic          s1_free;
   logic          s1_load;
   logic          do_event;
   logic          do_clear;
   logic [CB-1:0] picked;
   logic [CB-1:0] clamped;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_free  = !s1_valid_ff || out_free;
   assign pop      = head.valid && s1_free;
   assign do_event = pop && (head.cmd.kind == dcs_pkg::CMD_EVENT);
   assign do_clear = pop && (head.cmd.kind == dcs_pkg::CMD_CLEAR);
   assign s1_load  = pop && (head.cmd.kind != dcs_pkg::CMD_CLEAR);

   always_comb begin
      for (int j = 0; j < dcs_pkg::GROUP_SIZE; j++) begin
         group_in[j] = counters_ff[{head.cmd.index[5:3], 3'(j)}];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   assign picked  = s1_oob_ff ? '0 : group_ff[s1_low_ff];
   assign clamped = (picked > CB'(dcs_pkg::READ_MAX)) ? CB'(dcs_pkg::READ_MAX) : picked;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < dcs_pkg::NUM_COUNTERS; k++) begin
            counters_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < dcs_pkg::NUM_COUNTERS; k++) begin
            if (do_clear) begin
               counters_ff[k] <= '0;
            end else if (do_event &&
                         ((head.cmd.mask & dcs_pkg::SUBSET_MASKS[k]) ==
                          dcs_pkg::SUBSET_MASKS[k]) &&
                         (counters_ff[k] != {CB{1'b1}})) begin
               counters_ff[k] <= counters_ff[k] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_is_read_ff <= (head.cmd.kind == dcs_pkg::CMD_READ);
         s1_mask_ff    <= head.cmd.mask;
         s1_oob_ff     <= (head.cmd.index[7:6] != 2'd0);
         s1_low_ff     <= head.cmd.index[2:0];
         for (int j = 0; j < dcs_pkg::GROUP_SIZE; j++) begin
            group_ff[j] <= group_in[j];
         end
      end
      if (out_free && s1_valid_ff) begin
         rsp_is_read_ff <= s1_is_read_ff;
         rsp_mask_ff    <= s1_is_read_ff ? 6'd0 : s1_mask_ff;
         rsp_count_ff   <= s1_is_read_ff ? 32'(clamped) : 32'd0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_good_mask   = rsp_mask_ff;
   assign rsp_count_value = rsp_count_ff;
   assign rsp_is_read     = rsp_is_read_ff;

endmodule

[design/detector_coincidence_scaler_core.sv]
// ----------------------------------------------------------------------------
// detector_coincidence_scaler_core
// Event coincidence checks for six detectors with 64 saturating subset
// counters that can be read back or cleared.
// ----------------------------------------------------------------------------
// The req channel takes one word per cycle while req_ready is high: samples,
// end of event, counter reads and counter clears. Samples update the event
// state at the accepting edge and give no result. End of event forms the good
// mask at once, clears the event state and queues the mask for the counters,
// so the next event's samples may follow in the very next cycle. Reads and
// clears go through the same four-entry queue and keep their order with
// counter updates. The rsp channel returns one word per end of event and per
// read. Each end of event or read passes from the queue through the counter
// read stage to the rsp register. Throughput is one word per cycle while the
// receiver is ready; the queue and the counter read stage before rsp let words
// still enter while a result waits. When rsp stalls, the queue fills and
// req_ready falls once it holds four commands. The csr channel is always
// ready; write it only while the block is idle. Reset loads the register
// defaults, clears the event state, all counters and the queue.
// ----------------------------------------------------------------------------
module detector_coincidence_scaler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [2:0]  req_source,
   input  logic        req_chamber,
   input  logic [7:0]  req_channel,
   input  logic [15:0] req_sample_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_good_mask,
   output logic [31:0] rsp_count_value,
   output logic        rsp_is_read,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   dcs_pkg::cmd_slot_type push;
   dcs_pkg::cmd_slot_type head;
   logic                  queue_full;
   logic                  pop;

   dcs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_source       (req_source),
      .req_chamber      (req_chamber),
      .req_channel      (req_channel),
      .req_sample_value (req_sample_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .queue_full       (queue_full),
      .push             (push)
   );

   dcs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   dcs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_good_mask   (rsp_good_mask),
      .rsp_count_value (rsp_count_value),
      .rsp_is_read     (rsp_is_read)
   );

endmodule

[design/dcs_checker.sv]
// ----------------------------------------------------------------------------
// dcs_checker
// Port-level checks of the coincidence scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "detector_coincidence_scaler_core_defines.svh"

module dcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_good_mask,
   input logic [31:0] rsp_count_value,
   input logic        rsp_is_read
);

   `DCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_good_mask) && $stable(rsp_count_value) && $stable(rsp_is_read))

   `DCS_ASSERT_RESET(a_reset_idle, clock, reset, !rsp_valid)

   `DCS_ASSERT_NOW(a_read_no_mask, clock, reset, rsp_valid && rsp_is_read, rsp_good_mask == 6'd0)

   `DCS_ASSERT_NOW(a_event_no_count, clock, reset, rsp_valid && !rsp_is_read,
      rsp_count_value == 32'd0)

endmodule

bind detector_coincidence_scaler_core dcs_checker u_dcs_checker (.*);

[test/tb_detector_coincidence_scaler_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_detector_coincidence_scaler_core
// Self-checking bench for the coincidence scaler. A directed table covers
// window edges, ignored channels and sources, reads out of range and a clear.
// Random events with mostly well-formed detector content then run under six
// register settings, with random idling on both channels and one long
// receiver hold-off that backs the block up. Every result word is compared
// field by field against the directed table or the in-bench predictor.
// ----------------------------------------------------------------------------
module tb_detector_coincidence_scaler_core;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SQUEEZE_CYCLES = 300;
   localparam logic [2:0] SRC_SPARE = 3'd7;
   localparam logic [7:0] PMT_MAP [8] = '{8'd9, 8'd11, 8'd13, 8'd15,
                                          8'd1, 8'd3, 8'd5, 8'd7};
   localparam logic [7:0] MCP_HI [4] = '{8'd11, 8'd15, 8'd9, 8'd13};
   localparam logic [7:0] MCP_LO [4] = '{8'd3, 8'd7, 8'd1, 8'd5};

   typedef struct packed {
      dcs_pkg::op_type op;
      logic [2:0]      source;
      logic            chamber;
      logic [7:0]      channel;
      logic [15:0]     value;
   } word_type;

   typedef struct packed {
      logic [5:0]  mask;
      logic [31:0] count;
      logic        is_read;
   } rsp_type;

   typedef struct packed {
      word_type w;
      logic     typed;
      rsp_type  r;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_operation;
   logic [2:0]  req_source;
   logic        req_chamber;
   logic [7:0]  req_channel;
   logic [15:0] req_sample_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [5:0]  rsp_good_mask;
   logic [31:0] rsp_count_value;
   logic        rsp_is_read;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   // Predicted state of the scaler.
   logic [15:0] cfg_reg [8];
   logic [7:0]  ev_pmt;
   logic [3:0]  ev_mcp;
   logic        ev_anode [2];
   logic [8:0]  ev_pads [2];
   logic [4:0]  ev_ion;
   logic [31:0] scaler [64];
   logic [5:0]  subset_of [64];

   rsp_type  awaited_rsp [$];
   row_type  dir_rows [$];
   logic [15:0] phase_regs [8];
   int    failures = 0;
   int    cycle_count = 0;
   int    items_sent = 0;
   int    gap_ahead = 0;
   bit    no_gaps = 0;
   int    squeeze_asked = 0;
   int    squeeze_done = 0;

   detector_coincidence_scaler_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_source(req_source),
      .req_chamber(req_chamber),
      .req_channel(req_channel),
      .req_sample_value(req_sample_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_good_mask(rsp_good_mask),
      .rsp_count_value(rsp_count_value),
      .rsp_is_read(rsp_is_read),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [5:0] coincidence_mask();
      logic [5:0] g;
      g = '0;
      g[0] = (ev_pmt[3:0] == 4'hF);
      g[1] = (ev_mcp == 4'hF);
      g[2] = ev_anode[0] && (ev_pads[0] > 9'd2);
      g[3] = (ev_pmt[7:4] == 4'hF);
      g[4] = ev_anode[1] && (ev_pads[1] > 9'd2);
      g[5] = ({11'd0, ev_ion} >= cfg_reg[dcs_pkg::REG_ION_MIN]);
      return g;
   endfunction

   task automatic scaler_step(input word_type w, output bit has_rsp, output rsp_type r);
      logic [5:0] g;
      logic [15:0] v;
      v = w.value;
      has_rsp = 1'b0;
      r = '0;
      unique case (w.op)
         dcs_pkg::OP_SAMPLE: begin
            unique case (w.source)
               dcs_pkg::SRC_TDC: begin
                  for (int i = 0; i < 8; i++) begin
                     if (w.channel == PMT_MAP[i] && v > cfg_reg[dcs_pkg::REG_TDC_LOWER]
                         && v < cfg_reg[dcs_pkg::REG_TDC_UPPER]) begin
                        ev_pmt[i] = 1'b1;
                     end
                  end
               end
               dcs_pkg::SRC_QDC: begin
                  for (int i = 0; i < 4; i++) begin
                     if (w.channel == MCP_HI[i] && v > cfg_reg[dcs_pkg::REG_PED_HIGH]
                         && v < cfg_reg[dcs_pkg::REG_QDC_UPPER]) begin
                        ev_mcp[i] = 1'b1;
                     end
                     if (w.channel == MCP_LO[i] && v > cfg_reg[dcs_pkg::REG_PED_LOW]
                         && v < cfg_reg[dcs_pkg::REG_QDC_UPPER]) begin
                        ev_mcp[i] = 1'b1;
                     end
                  end
               end
               dcs_pkg::SRC_PAD: begin
                  if (v > cfg_reg[dcs_pkg::REG_PAD_LOWER]
                      && v < cfg_reg[dcs_pkg::REG_PAD_UPPER]
                      && ev_pads[w.chamber] != 9'd511) begin
                     ev_pads[w.chamber] = ev_pads[w.chamber] + 9'd1;
                  end
               end
               dcs_pkg::SRC_ANODE: begin
                  if (v > 16'd10 && v < 16'd4080) begin
                     ev_anode[w.chamber] = 1'b1;
                  end
               end
               dcs_pkg::SRC_ION: begin
                  if (w.channel < 8'd16 && v > 16'd10 && v < 16'd4080
                      && ev_ion != 5'd31) begin
                     ev_ion = ev_ion + 5'd1;
                  end
               end
               default: begin
               end
            endcase
         end
         dcs_pkg::OP_EVENT: begin
            g = coincidence_mask();
            for (int k = 0; k < 64; k++) begin
               if ((g & subset_of[k]) == subset_of[k] && scaler[k] != '1) begin
                  scaler[k] = scaler[k] + 32'd1;
               end
            end
            ev_pmt = '0;
            ev_mcp = '0;
            ev_anode[0] = 1'b0;
            ev_anode[1] = 1'b0;
            ev_pads[0] = '0;
            ev_pads[1] = '0;
            ev_ion = '0;
            has_rsp = 1'b1;
            r.mask = g;
         end
         dcs_pkg::OP_READ: begin
            has_rsp = 1'b1;
            r.is_read = 1'b1;
            if (w.channel < 8'd64) begin
               r.count = scaler[w.channel[5:0]];
            end
         end
         default: begin
            for (int k = 0; k < 64; k++) begin
               scaler[k] = '0;
            end
         end
      endcase
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(5, 30);
      end
   endfunction

   function automatic logic [15:0] pick_value(input int lo, input int hi);
      int r;
      r = $urandom_range(0, 9);
      if (r < 6 && hi - lo >= 2) begin
         return 16'($urandom_range(lo + 1, hi - 1));
      end else if (r == 6) begin
         return 16'(lo);
      end else if (r == 7) begin
         return 16'(hi);
      end else if (r == 8) begin
         return 16'(lo + 1);
      end else begin
         return 16'($urandom_range(0, 65535));
      end
   endfunction

   task automatic push_word(input word_type w, input bit typed, input rsp_type typed_rsp);
      bit      got;
      rsp_type r;
      if (gap_ahead > 0) begin
         repeat (gap_ahead) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= w.op;
      req_source <= w.source;
      req_chamber <= w.chamber;
      req_channel <= w.channel;
      req_sample_value <= w.value;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      scaler_step(w, got, r);
      if (got) begin
         awaited_rsp.push_back(typed ? typed_rsp : r);
      end
      items_sent++;
      gap_ahead = no_gaps ? 0 : pick_gap();
      if (gap_ahead > 0) begin
         req_valid <= 1'b0;
      end
   endtask

   task automatic push_sample(input logic [2:0] src, input logic chamber,
                              input logic [7:0] channel, input logic [15:0] value);
      word_type w;
      w = '{dcs_pkg::OP_SAMPLE, src, chamber, channel, value};
      push_word(w, 1'b0, '0);
   endtask

   task automatic push_cmd(input dcs_pkg::op_type op, input logic [7:0] channel);
      word_type w;
      w = '{op, dcs_pkg::SRC_TDC, 1'($urandom_range(0, 1)), channel,
            16'($urandom_range(0, 65535))};
      push_word(w, 1'b0, '0);
   endtask

   function automatic logic [7:0] pick_counter();
      if ($urandom_range(0, 9) == 0) begin
         return 8'($urandom_range(64, 255));
      end
      return 8'($urandom_range(0, 63));
   endfunction

   // Waits until every result has come back, then lets a clear still in
   // the command queue drain.
   task automatic settle_block();
      if (gap_ahead == 0) begin
         req_valid <= 1'b0;
      end
      gap_ahead = 0;
      while (awaited_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
   endtask

   // One event with random content, at times with a clear and reads. Most detectors
   // get a full set of samples, some are left incomplete, and a little noise is mixed in.
   task automatic make_event();
      int n;
      logic hi_gain;
      logic [7:0] ch;
      if ($urandom_range(0, 3) != 0) begin
         for (int k = 0; k < 8; k++) begin
            if ($urandom_range(0, 7) != 0) begin
               ch = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : PMT_MAP[k];
               push_sample(dcs_pkg::SRC_TDC, 1'($urandom_range(0, 1)), ch,
                           pick_value(cfg_reg[dcs_pkg::REG_TDC_LOWER],
                                      cfg_reg[dcs_pkg::REG_TDC_UPPER]));
            end
         end
      end
      if ($urandom_range(0, 3) != 0) begin
         for (int k = 0; k < 4; k++) begin
            hi_gain = 1'($urandom_range(0, 1));
            ch = hi_gain ? MCP_HI[k] : MCP_LO[k];
            push_sample(dcs_pkg::SRC_QDC, 1'($urandom_range(0, 1)), ch,
                        pick_value(hi_gain ? cfg_reg[dcs_pkg::REG_PED_HIGH]
                                           : cfg_reg[dcs_pkg::REG_PED_LOW],
                                   cfg_reg[dcs_pkg::REG_QDC_UPPER]));
         end
      end
      for (int c = 0; c < 2; c++) begin
         if ($urandom_range(0, 4) != 0) begin
            push_sample(dcs_pkg::SRC_ANODE, 1'(c), 8'($urandom_range(0, 255)),
                        pick_value(10, 4080));
         end
         n = $urandom_range(0, 6);
         repeat (n) begin
            push_sample(dcs_pkg::SRC_PAD, 1'(c), 8'($urandom_range(0, 255)),
                        pick_value(cfg_reg[dcs_pkg::REG_PAD_LOWER],
                                   cfg_reg[dcs_pkg::REG_PAD_UPPER]));
         end
      end
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(12, 18) : $urandom_range(0, 34);
      repeat (n) begin
         ch = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 15));
         push_sample(dcs_pkg::SRC_ION, 1'($urandom_range(0, 1)), ch, pick_value(10, 4080));
      end
      n = $urandom_range(0, 2);
      repeat (n) begin
         push_sample(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      end
      if ($urandom_range(0, 11) == 0) begin
         push_cmd(dcs_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
      end
      push_cmd(dcs_pkg::OP_EVENT, 8'($urandom_range(0, 255)));
      n = $urandom_range(0, 2);
      repeat (n) begin
         push_cmd(dcs_pkg::OP_READ, pick_counter());
      end
   endtask

   function automatic row_type sample_row(input logic [2:0] src, input logic chamber,
                                          input logic [7:0] channel,
                                          input logic [15:0] value);
      row_type t;
      t = '0;
      t.w = '{dcs_pkg::OP_SAMPLE, src, chamber, channel, value};
      return t;
   endfunction

   function automatic row_type cmd_row(input dcs_pkg::op_type op, input logic [7:0] channel,
                                       input logic typed, input logic [5:0] mask,
                                       input logic [31:0] count, input logic is_read);
      row_type t;
      t = '0;
      t.w = '{op, dcs_pkg::SRC_TDC, 1'b0, channel, 16'd0};
      t.typed = typed;
      t.r = '{mask, count, is_read};
      return t;
   endfunction

   // Receiver: checks each result word and idles at random.
   initial begin
      int      hold;
      int      calm;
      int      r;
      rsp_type got;
      rsp_type want;
      hold = 0;
      calm = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = {rsp_good_mask, rsp_count_value, rsp_is_read};
            if (awaited_rsp.size() == 0) begin
               $error("unexpected result word: good_mask %0d count_value %0d is_read %0d",
                      got.mask, got.count, got.is_read);
               failures++;
            end else begin
               want = awaited_rsp.pop_front();
               if (got.mask !== want.mask) begin
                  $error("good_mask: expected %0d, actual %0d", want.mask, got.mask);
                  failures++;
               end
               if (got.count !== want.count) begin
                  $error("count_value: expected %0d, actual %0d", want.count, got.count);
                  failures++;
               end
               if (got.is_read !== want.is_read) begin
                  $error("is_read: expected %0d, actual %0d", want.is_read, got.is_read);
                  failures++;
               end
            end
         end
         if (squeeze_done != squeeze_asked) begin
            squeeze_done++;
            hold = SQUEEZE_CYCLES;
            calm = 0;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else if (calm > 0) begin
            rsp_ready <= 1'b1;
            calm--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
               calm = $urandom_range(20, 60);
               rsp_ready <= 1'b1;
            end else if (r < 70) begin
               rsp_ready <= 1'b1;
            end else if (r < 95) begin
               hold = $urandom_range(0, 2);
               rsp_ready <= 1'b0;
            end else begin
               hold = $urandom_range(9, 39);
               rsp_ready <= 1'b0;
            end
         end
      end
   end

   // Stimulus.
   initial begin
      int start;
      int idx;
      dcs_pkg::reg_index_type ri;
      logic [15:0] v;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= dcs_pkg::OP_SAMPLE;
      req_source <= dcs_pkg::SRC_TDC;
      req_chamber <= 1'b0;
      req_channel <= '0;
      req_sample_value <= '0;
      csr_valid <= 1'b0;
      csr_index <= dcs_pkg::REG_TDC_LOWER;
      csr_data <= '0;

      cfg_reg[dcs_pkg::REG_TDC_LOWER] = 16'd1;
      cfg_reg[dcs_pkg::REG_TDC_UPPER] = 16'd65535;
      cfg_reg[dcs_pkg::REG_QDC_UPPER] = 16'd3840;
      cfg_reg[dcs_pkg::REG_PED_HIGH] = 16'd100;
      cfg_reg[dcs_pkg::REG_PED_LOW] = 16'd20;
      cfg_reg[dcs_pkg::REG_PAD_LOWER] = 16'd100;
      cfg_reg[dcs_pkg::REG_PAD_UPPER] = 16'd990;
      cfg_reg[dcs_pkg::REG_ION_MIN] = 16'd15;
      ev_pmt = '0;
      ev_mcp = '0;
      ev_anode[0] = 1'b0;
      ev_anode[1] = 1'b0;
      ev_pads[0] = '0;
      ev_pads[1] = '0;
      ev_ion = '0;
      for (int k = 0; k < 64; k++) begin
         scaler[k] = '0;
      end

      // Counter order: by subset size, and within a size by descending
      // index with the detector bits mirrored.
      idx = 0;
      for (int s = 0; s <= 6; s++) begin
         for (int r = 63; r >= 0; r--) begin
            if ($countones(6'(r)) == s) begin
               for (int b = 0; b < 6; b++) begin
                  subset_of[idx][5 - b] = r[b];
               end
               idx++;
            end
         end
      end

      dir_rows.push_back(cmd_row(dcs_pkg::OP_READ, 8'd0, 1'b1, 6'd0, 32'd0, 1'b1));
      dir_rows.push_back(cmd_row(dcs_pkg::OP_READ, 8'd255, 1'b1, 6'd0, 32'd0, 1'b1));
      dir_rows.push_back(cmd_row(dcs_pkg::OP_EVENT, 8'd0, 1'b1, 6'd0, 32'd0, 1'b0));
      dir_rows.push_back(cmd_row(dcs_pkg::OP_READ, 8'd0, 1'b1, 6'd0, 32'd1, 1'b1));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_TDC, 1'b0, 8'd9, 16'd65535));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_TDC, 1'b1, 8'd9, 16'd1));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_TDC, 1'b0, 8'd11, 16'd2));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_TDC, 1'b0, 8'd7, 16'd0));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_QDC, 1'b0, 8'd11, 16'd3840));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_QDC, 1'b0, 8'd3, 16'd21));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_QDC, 1'b0, 8'd0, 16'd4095));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_PAD, 1'b1, 8'd255, 16'd989));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_PAD, 1'b1, 8'd0, 16'd100));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_PAD, 1'b1, 8'd128, 16'd500));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_PAD, 1'b1, 8'd255, 16'd990));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_ANODE, 1'b0, 8'd0, 16'd4080));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_ANODE, 1'b1, 8'd0, 16'd11));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_ION, 1'b0, 8'd16, 16'd100));
      dir_rows.push_back(sample_row(dcs_pkg::SRC_ION, 1'b0, 8'd15, 16'd4079));
      dir_rows.push_back(sample_row(SRC_SPARE, 1'b1, 8'd255, 16'd65535));
      dir_rows.push_back(cmd_row(dcs_pkg::OP_EVENT, 8'd0, 1'b0, 6'd0, 32'd0, 1'b0));
      dir_rows.push_back(cmd_row(dcs_pkg::OP_CLEAR, 8'd0, 1'b0, 6'd0, 32'd0, 1'b0));
      dir_rows.push_back(cmd_row(dcs_pkg::OP_READ, 8'd0, 1'b1, 6'd0, 32'd0, 1'b1));
      dir_rows.push_back(cmd_row(dcs_pkg::OP_READ, 8'd63, 1'b1, 6'd0, 32'd0, 1'b1));
      dir_rows.push_back(cmd_row(dcs_pkg::OP_EVENT, 8'd0, 1'b0, 6'd0, 32'd0, 1'b0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         push_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);
      end

      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            settle_block();
            unique case (phase)
               1: begin
                  phase_regs[dcs_pkg::REG_TDC_LOWER] = 16'd0;
                  phase_regs[dcs_pkg::REG_TDC_UPPER] = 16'd65535;
                  phase_regs[dcs_pkg::REG_QDC_UPPER] = 16'd4095;
                  phase_regs[dcs_pkg::REG_PED_HIGH] = 16'd0;
                  phase_regs[dcs_pkg::REG_PED_LOW] = 16'd0;
                  phase_regs[dcs_pkg::REG_PAD_LOWER] = 16'd0;
                  phase_regs[dcs_pkg::REG_PAD_UPPER] = 16'd4095;
                  phase_regs[dcs_pkg::REG_ION_MIN] = 16'd0;
               end
               2: begin
                  phase_regs[dcs_pkg::REG_TDC_LOWER] = 16'd65535;
                  phase_regs[dcs_pkg::REG_TDC_UPPER] = 16'd0;
                  phase_regs[dcs_pkg::REG_QDC_UPPER] = 16'd0;
                  phase_regs[dcs_pkg::REG_PED_HIGH] = 16'd4095;
                  phase_regs[dcs_pkg::REG_PED_LOW] = 16'd4095;
                  phase_regs[dcs_pkg::REG_PAD_LOWER] = 16'd4095;
                  phase_regs[dcs_pkg::REG_PAD_UPPER] = 16'd0;
                  phase_regs[dcs_pkg::REG_ION_MIN] = 16'd16;
               end
               5: begin
                  phase_regs[dcs_pkg::REG_TDC_LOWER] = 16'd1;
                  phase_regs[dcs_pkg::REG_TDC_UPPER] = 16'd65535;
                  phase_regs[dcs_pkg::REG_QDC_UPPER] = 16'd3840;
                  phase_regs[dcs_pkg::REG_PED_HIGH] = 16'd100;
                  phase_regs[dcs_pkg::REG_PED_LOW] = 16'd20;
                  phase_regs[dcs_pkg::REG_PAD_LOWER] = 16'd100;
                  phase_regs[dcs_pkg::REG_PAD_UPPER] = 16'd990;
                  phase_regs[dcs_pkg::REG_ION_MIN] = 16'd15;
               end
               default: begin
                  phase_regs[dcs_pkg::REG_TDC_LOWER] = 16'($urandom_range(0, 40000));
                  phase_regs[dcs_pkg::REG_TDC_UPPER] =
                     16'($urandom_range(phase_regs[dcs_pkg::REG_TDC_LOWER], 65535));
                  phase_regs[dcs_pkg::REG_QDC_UPPER] = 16'($urandom_range(2000, 4095));
                  phase_regs[dcs_pkg::REG_PED_HIGH] = 16'($urandom_range(0, 1500));
                  phase_regs[dcs_pkg::REG_PED_LOW] = 16'($urandom_range(0, 500));
                  phase_regs[dcs_pkg::REG_PAD_LOWER] = 16'($urandom_range(0, 1000));
                  phase_regs[dcs_pkg::REG_PAD_UPPER] =
                     16'($urandom_range(phase_regs[dcs_pkg::REG_PAD_LOWER], 4095));
                  phase_regs[dcs_pkg::REG_ION_MIN] = 16'($urandom_range(0, 16));
               end
            endcase
            for (int i = 0; i < 8; i++) begin
               ri = dcs_pkg::reg_index_type'(i);
               v = phase_regs[ri];
               csr_valid <= 1'b1;
               csr_index <= ri;
               csr_data <= v;
               @(posedge clock);
               while (!csr_ready) begin
                  @(posedge clock);
               end
               unique case (ri)
                  dcs_pkg::REG_TDC_LOWER, dcs_pkg::REG_TDC_UPPER: cfg_reg[ri] = v;
                  dcs_pkg::REG_ION_MIN: cfg_reg[ri] = {11'd0, v[4:0]};
                  default: cfg_reg[ri] = {4'd0, v[11:0]};
               endcase
            end
            csr_valid <= 1'b0;
         end
         if (phase == 4) begin
            // Hold the receiver off while reads pour in, so the command
            // queue fills and the block pushes back on req.
            squeeze_asked++;
            no_gaps = 1'b1;
            repeat (24) begin
               push_cmd(dcs_pkg::OP_READ, pick_counter());
            end
            no_gaps = 1'b0;
         end
         start = items_sent;
         while (items_sent - start < 80) begin
            make_event();
         end
         repeat (6) begin
            push_cmd(dcs_pkg::OP_READ, pick_counter());
         end
      end

      settle_block();
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
